// ===== rtl/mvna_pkg.sv =====
//------------------------------------------------------------------------------
// mvna_pkg: shared types and constants of the vertex normal accumulator
// Item kinds, sequencer states and default memory size.
//------------------------------------------------------------------------------
`default_nettype none

package mvna_pkg;

   localparam int MemWordsDefault = 4096;

   // item kinds
   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_TRI   = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RANGE,
      ST_RD_ISSUE,
      ST_RD_TAKE,
      ST_EDGE,
      ST_MUL,
      ST_CROSS,
      ST_ABS,
      ST_NORM,
      ST_SQ,
      ST_SQRT,
      ST_DIV,
      ST_DIV_END,
      ST_ACC_RD,
      ST_ACC_WAIT,
      ST_ACC_WR,
      ST_RD_WORD,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/mesh_vertex_normal_accumulator_top.sv =====
//------------------------------------------------------------------------------
// mesh_vertex_normal_accumulator_top: vertex memory with triangle normals
// Word memory of Q16.16 vertex records; adds unit face normals into vertices.
//------------------------------------------------------------------------------
// One item is in work at a time; req_ready is low until its beat has left on
// the rsp channel. A triangle item whose records lie in memory runs three base
// products, nine word fetches over the memory read port, six sequential
// products on one shared 33x33 multiplier, a normalising shift, three squares
// on the same multiplier, a 32-step bit-pair square root and three 48-step
// restoring divisions with a rounding step each on one shared divider, then
// nine read-modify-write passes over the memory port. A degenerate triangle
// ends after the normalising check and one that reaches outside memory before
// its first word fetch. A stalled rsp channel adds its stall. The memory
// has no clearing pass; words never written read as anything.
`default_nettype none

module mesh_vertex_normal_accumulator_top
   import mvna_pkg::*;
#(
   parameter int MEMORY_WORDS = MemWordsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [11:0] req_word_address,
   input  wire logic signed [31:0] req_word_value,
   input  wire logic [11:0] req_vertex_a,
   input  wire logic [11:0] req_vertex_b,
   input  wire logic [11:0] req_vertex_c,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic             rsp_range_error,
   input  wire logic        csr_write_enable,
   input  wire logic [6:0]  csr_write_data
);

   localparam int AW = $clog2(MEMORY_WORDS);

   // vertex memory
   logic [31:0] mem [MEMORY_WORDS];
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [31:0]   mem_wdata, mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      mem_rdata_ff <= mem[mem_raddr];
   end

   // stride register
   logic [6:0] stride_ff;
   always_ff @(posedge clock) begin
      if (reset) stride_ff <= 7'd8;
      else if (csr_write_enable) stride_ff <= csr_write_data;
   end

   state_type state_ff, state_in;

   logic [1:0]  kind_ff;
   logic [11:0] addr_ff;
   logic [31:0] val_ff;
   logic [11:0] vtx_ff [3];
   logic [18:0] base_ff [3];
   logic signed [31:0] pos_ff [9];
   logic signed [31:0] e_ff [6];      // e1 x,y,z then e2 x,y,z
   logic signed [62:0] term_ff [6];
   logic signed [63:0] c_ff [3];
   logic [63:0] m_ff [3];
   logic [2:0]  neg_ff;
   logic [63:0] sum_ff;
   logic [63:0] sq_v_ff, sq_r_ff;
   logic [5:0]  sq_k_ff;
   logic [47:0] dv_q_ff;
   logic [31:0] dv_r_ff;
   logic [5:0]  dv_k_ff;
   logic [31:0] len_ff;
   logic signed [31:0] n_ff [3];
   logic [3:0]  cnt_ff, cnt_in;
   logic [1:0]  j_ff, j_in;
   logic        err_ff;
   logic [31:0] rv_ff;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x > 33'sd2147483647) r = 32'sh7fffffff;
      else if (x < -33'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] rnd_q(input logic [47:0] q,
                                                input logic [31:0] r,
                                                input logic [31:0] l);
      logic [32:0] r2;
      r2 = {r, 1'b0};
      return (r2 >= 33'(l)) ? 32'(q) + 32'd1 : 32'(q);
   endfunction

   // shared multiplier operand select
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL: begin
            case (cnt_ff[2:0])
               3'd0: begin mul_a = 33'(e_ff[1]); mul_b = 33'(e_ff[5]); end
               3'd1: begin mul_a = 33'(e_ff[2]); mul_b = 33'(e_ff[4]); end
               3'd2: begin mul_a = 33'(e_ff[2]); mul_b = 33'(e_ff[3]); end
               3'd3: begin mul_a = 33'(e_ff[0]); mul_b = 33'(e_ff[5]); end
               3'd4: begin mul_a = 33'(e_ff[0]); mul_b = 33'(e_ff[4]); end
               default: begin mul_a = 33'(e_ff[1]); mul_b = 33'(e_ff[3]); end
            endcase
         end
         ST_SQ: begin
            mul_a = {3'b000, m_ff[j_ff][29:0]};
            mul_b = {3'b000, m_ff[j_ff][29:0]};
         end
         default: ;
      endcase
      mul_p = mul_a * mul_b;
   end

   // normalising shift of one bit per cycle
   logic [63:0] mx;
   always_comb begin
      mx = m_ff[0];
      if (m_ff[1] > mx) mx = m_ff[1];
      if (m_ff[2] > mx) mx = m_ff[2];
   end

   // square root step
   logic [63:0] sq_bit, sq_try;
   always_comb begin
      sq_bit = 64'd1 << {sq_k_ff, 1'b0};
      sq_try = sq_r_ff + sq_bit;
   end

   // restoring divider step
   logic [32:0] dv_sh;
   logic [33:0] dv_diff;
   always_comb begin
      dv_sh   = {dv_r_ff, dv_q_ff[47]};
      dv_diff = {1'b0, dv_sh} - {2'b00, len_ff};
   end

   // address generation for fetch and accumulate
   logic [1:0]  vi;
   logic [1:0]  wi;
   always_comb begin
      if (cnt_ff >= 4'd6) vi = 2'd2;
      else if (cnt_ff >= 4'd3) vi = 2'd1;
      else vi = 2'd0;
      wi = 2'(cnt_ff - 4'(vi) * 4'd3);
   end
   logic [19:0] fetch_addr;
   assign fetch_addr = 20'(base_ff[vi]) + 20'(wi);

   // saturating add for accumulate
   logic signed [32:0] acc_sum;
   logic [31:0]        acc_sat;
   always_comb begin
      acc_sum = 33'(signed'(mem_rdata_ff)) + 33'(n_ff[wi]);
      if (acc_sum > 33'sd2147483647) acc_sat = 32'h7fffffff;
      else if (acc_sum < -33'sd2147483648) acc_sat = 32'h80000000;
      else acc_sat = acc_sum[31:0];
   end

   // base address product of one vertex per cycle
   logic [18:0] base_p;
   assign base_p = 19'(vtx_ff[cnt_ff[1:0]]) * 19'(stride_ff);

   // sequencer next state and memory controls
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      j_in      = j_ff;
      mem_we    = 1'b0;
      mem_waddr = AW'(addr_ff);
      mem_wdata = val_ff;
      mem_raddr = AW'(addr_ff);
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in = '0;
            if (req_valid) begin
               unique case (kind_type'(req_kind)) inside
                  KIND_WRITE, KIND_READ, KIND_TRI: state_in = ST_RANGE;
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RANGE: begin
            if (kind_type'(kind_ff) == KIND_TRI) begin
               if (cnt_ff == 4'd2) begin
                  cnt_in = '0;
                  state_in = ST_RD_ISSUE;
               end else cnt_in = cnt_ff + 4'd1;
            end else if (32'(addr_ff) >= 32'(MEMORY_WORDS)) state_in = ST_RESP;
            else if (kind_type'(kind_ff) == KIND_WRITE) begin
               mem_we = 1'b1;
               state_in = ST_RESP;
            end else state_in = ST_RD_WORD;
         end
         ST_RD_WORD: state_in = ST_RESP;
         ST_RD_ISSUE: begin
            if (err_ff) state_in = ST_RESP;
            else begin
               mem_raddr = fetch_addr[AW-1:0];
               state_in = ST_RD_TAKE;
            end
         end
         ST_RD_TAKE: begin
            if (cnt_ff == 4'd8) begin
               cnt_in = '0;
               state_in = ST_EDGE;
            end else begin
               cnt_in = cnt_ff + 4'd1;
               state_in = ST_RD_ISSUE;
            end
         end
         ST_EDGE: state_in = ST_MUL;
         ST_MUL: begin
            if (cnt_ff == 4'd5) begin
               cnt_in = '0;
               state_in = ST_CROSS;
            end else cnt_in = cnt_ff + 4'd1;
         end
         ST_CROSS: state_in = ST_ABS;
         ST_ABS: state_in = ST_NORM;
         ST_NORM: begin
            if (mx == 64'd0) state_in = ST_RESP;
            else if (mx[63:30] == '0 && mx[29]) begin
               j_in = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (j_ff == 2'd2) state_in = ST_SQRT;
            else j_in = j_ff + 2'd1;
         end
         ST_SQRT: begin
            if (sq_k_ff == '0) begin
               j_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: if (dv_k_ff == 6'd47) state_in = ST_DIV_END;
         ST_DIV_END: begin
            if (j_ff == 2'd2) begin
               cnt_in = '0;
               state_in = ST_ACC_RD;
            end else begin
               j_in = j_ff + 2'd1;
               state_in = ST_DIV;
            end
         end
         ST_ACC_RD: begin
            mem_raddr = AW'(fetch_addr + 20'd3);
            state_in = ST_ACC_WAIT;
         end
         // hold the address so the read word stays put for the write cycle
         ST_ACC_WAIT: begin
            mem_raddr = AW'(fetch_addr + 20'd3);
            state_in = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(fetch_addr + 20'd3);
            mem_wdata = acc_sat;
            if (cnt_ff == 4'd8) state_in = ST_RESP;
            else begin
               cnt_in = cnt_ff + 4'd1;
               state_in = ST_ACC_RD;
            end
         end
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      j_ff   <= j_in;
      unique case (state_ff)
         ST_IDLE: begin
            kind_ff <= req_kind;
            addr_ff <= req_word_address;
            val_ff  <= req_word_value;
            vtx_ff[0] <= req_vertex_a;
            vtx_ff[1] <= req_vertex_b;
            vtx_ff[2] <= req_vertex_c;
            err_ff <= 1'b0;
            rv_ff  <= '0;
         end
         ST_RANGE: begin
            if (kind_type'(kind_ff) == KIND_TRI) begin
               base_ff[cnt_ff[1:0]] <= base_p;
               if (32'(base_p) + 32'd5 >= 32'(MEMORY_WORDS)) err_ff <= 1'b1;
            end else if (32'(addr_ff) >= 32'(MEMORY_WORDS)) err_ff <= 1'b1;
         end
         ST_RD_WORD: rv_ff <= mem_rdata_ff;
         ST_RD_TAKE: pos_ff[cnt_ff] <= mem_rdata_ff;
         ST_EDGE: begin
            for (int k = 0; k < 3; k++) begin
               e_ff[k]   <= sat32(33'(pos_ff[3+k]) - 33'(pos_ff[k]));
               e_ff[3+k] <= sat32(33'(pos_ff[6+k]) - 33'(pos_ff[k]));
            end
         end
         ST_MUL: term_ff[cnt_ff[2:0]] <= mul_p[63:1];
         ST_CROSS: begin
            c_ff[0] <= 64'(term_ff[0]) - 64'(term_ff[1]);
            c_ff[1] <= 64'(term_ff[2]) - 64'(term_ff[3]);
            c_ff[2] <= 64'(term_ff[4]) - 64'(term_ff[5]);
         end
         ST_ABS: begin
            for (int k = 0; k < 3; k++) begin
               neg_ff[k] <= c_ff[k][63];
               m_ff[k]   <= c_ff[k][63] ? 64'(-c_ff[k]) : 64'(c_ff[k]);
            end
            sum_ff <= '0;
         end
         ST_NORM: begin
            if (mx[63:30] != '0) begin
               for (int k = 0; k < 3; k++) m_ff[k] <= m_ff[k] >> 1;
            end else if (!mx[29]) begin
               for (int k = 0; k < 3; k++) m_ff[k] <= m_ff[k] << 1;
            end
         end
         ST_SQ: begin
            sum_ff <= sum_ff + 64'(mul_p[59:0]);
            sq_k_ff <= 6'd31;
            sq_r_ff <= '0;
            sq_v_ff <= sum_ff + 64'(mul_p[59:0]);
         end
         ST_SQRT: begin
            if (sq_v_ff >= sq_try) begin
               sq_v_ff <= sq_v_ff - sq_try;
               sq_r_ff <= (sq_r_ff >> 1) + sq_bit;
            end else sq_r_ff <= sq_r_ff >> 1;
            sq_k_ff <= sq_k_ff - 6'd1;
            dv_k_ff <= '0;
            dv_r_ff <= '0;
            dv_q_ff <= {m_ff[0][31:0], 16'd0};
            if (sq_k_ff == '0) begin
               if (sq_v_ff >= sq_try) len_ff <= 32'((sq_r_ff >> 1) + sq_bit);
               else len_ff <= 32'(sq_r_ff >> 1);
            end
         end
         ST_DIV: begin
            if (!dv_diff[33]) begin
               dv_r_ff <= dv_diff[31:0];
               dv_q_ff <= {dv_q_ff[46:0], 1'b1};
            end else begin
               dv_r_ff <= dv_sh[31:0];
               dv_q_ff <= {dv_q_ff[46:0], 1'b0};
            end
            dv_k_ff <= dv_k_ff + 6'd1;
         end
         ST_DIV_END: begin
            // round half up: quotient + (2*rem >= len)
            n_ff[j_ff] <= neg_ff[j_ff] ? -rnd_q(dv_q_ff, dv_r_ff, len_ff)
                                      : rnd_q(dv_q_ff, dv_r_ff, len_ff);
            dv_k_ff <= '0;
            dv_r_ff <= '0;
            dv_q_ff <= {m_ff[(j_ff == 2'd2) ? 2'd2 : j_ff + 2'd1][31:0], 16'd0};
         end
         default: ;
      endcase
   end

   // response beat
   assign rsp_valid       = (state_ff == ST_RESP);
   assign rsp_read_value  = rv_ff;
   assign rsp_range_error = err_ff;

   // checks
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken while busy");
   a_wr_only_seq: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_RANGE || state_ff == ST_ACC_WR))
      else $error("stray memory write");
   a_rsp_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (state_ff == ST_IDLE))
      else $error("response beat not retired");
   a_err_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_read_value == '0))
      else $error("errored beat carries data");

endmodule

`default_nettype wire

// ===== bench/tb_mesh_vertex_normal_accumulator_top.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_mesh_vertex_normal_accumulator_top: self-checking bench of the normal
// accumulator
// Loads vertex records under several strides, then runs word writes, reads
// and triangles with random gaps on both channels. Every accepted request
// is folded into a local copy of the vertex memory, and each response beat
// is compared with the oldest predicted word and range flag.
//------------------------------------------------------------------------------
module tb_mesh_vertex_normal_accumulator_top;
   import mvna_pkg::*;

   localparam int Words = 4096;

   typedef struct {
      kind_type           kind;
      logic [11:0]        addr;
      logic signed [31:0] value;
      logic [11:0]        va;
      logic [11:0]        vb;
      logic [11:0]        vc;
   } req_item_type;

   typedef struct {
      logic signed [31:0] word;
      logic               range_err;
   } rsp_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = '0;
   logic [11:0]        req_word_address = '0;
   logic signed [31:0] req_word_value = '0;
   logic [11:0]        req_vertex_a = '0;
   logic [11:0]        req_vertex_b = '0;
   logic [11:0]        req_vertex_c = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic               rsp_range_error;
   logic               csr_write_enable = 1'b0;
   logic [6:0]         csr_write_data = '0;

   mesh_vertex_normal_accumulator_top #(.MEMORY_WORDS(Words)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_word_address(req_word_address), .req_word_value(req_word_value),
      .req_vertex_a(req_vertex_a), .req_vertex_b(req_vertex_b),
      .req_vertex_c(req_vertex_c),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value), .rsp_range_error(rsp_range_error),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // shadow of the vertex memory and the stride
   logic [31:0]   shadow_mem [Words];
   int unsigned   shadow_stride = 8;

   req_item_type  pending_reqs[$];
   rsp_item_type  expected_rsps[$];
   int            n_queued = 0;
   int            n_checked = 0;
   int            n_fail = 0;

   // stimulus bookkeeping: words known to hold a value
   bit            gen_written [Words];
   logic [11:0]   written_addrs[$];
   logic [11:0]   verts [8];

   initial begin
      forever #10 clock = ~clock;
   end

   // gap length: mostly none or short, a few long
   function automatic int gap_len(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint sat32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // unit face normal added into all three vertices; returns the range flag
   function automatic logic accumulate_face(logic [11:0] va, logic [11:0] vb,
                                            logic [11:0] vc);
      int unsigned     base [3];
      longint          p [3][3];
      longint          e1 [3];
      longint          e2 [3];
      longint          c [3];
      longint unsigned m [3];
      longint unsigned mx;
      longint unsigned len;
      longint unsigned q;
      longint          n [3];
      base[0] = va * shadow_stride;
      base[1] = vb * shadow_stride;
      base[2] = vc * shadow_stride;
      for (int i = 0; i < 3; i++)
         if (base[i] + 5 >= Words) return 1'b1;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            p[i][j] = longint'($signed(shadow_mem[base[i] + j]));
      for (int j = 0; j < 3; j++) begin
         e1[j] = sat32(p[1][j] - p[0][j]);
         e2[j] = sat32(p[2][j] - p[0][j]);
      end
      c[0] = ((e1[1] * e2[2]) >>> 1) - ((e1[2] * e2[1]) >>> 1);
      c[1] = ((e1[2] * e2[0]) >>> 1) - ((e1[0] * e2[2]) >>> 1);
      c[2] = ((e1[0] * e2[1]) >>> 1) - ((e1[1] * e2[0]) >>> 1);
      mx = 0;
      for (int j = 0; j < 3; j++) begin
         m[j] = (c[j] < 0) ? longint'(-c[j]) : longint'(c[j]);
         if (m[j] > mx) mx = m[j];
      end
      // degenerate face adds nothing
      if (mx == 0) return 1'b0;
      while (mx >= (64'd1 << 30)) begin
         for (int j = 0; j < 3; j++) m[j] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int j = 0; j < 3; j++) m[j] <<= 1;
         mx <<= 1;
      end
      len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int j = 0; j < 3; j++) begin
         q = ((m[j] << 16) + (len >> 1)) / len;
         n[j] = (c[j] < 0) ? -longint'(q) : longint'(q);
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            shadow_mem[base[i] + 3 + j] =
               32'(sat32(longint'($signed(shadow_mem[base[i] + 3 + j])) + n[j]));
      return 1'b0;
   endfunction

   function automatic rsp_item_type predict_rsp(req_item_type it);
      rsp_item_type r;
      r.word = '0;
      r.range_err = 1'b0;
      case (it.kind)
         KIND_WRITE: begin
            shadow_mem[it.addr] = it.value;
         end
         KIND_READ: begin
            r.word = shadow_mem[it.addr];
         end
         KIND_TRI: begin
            r.range_err = accumulate_face(it.va, it.vb, it.vc);
         end
         default: ;
      endcase
      return r;
   endfunction

   // request building: unused fields carry random bits
   function automatic req_item_type blank_req(kind_type k);
      req_item_type it;
      it.kind = k;
      it.addr = 12'($urandom);
      it.value = $urandom;
      it.va = 12'($urandom);
      it.vb = 12'($urandom);
      it.vc = 12'($urandom);
      return it;
   endfunction

   task automatic push_req(req_item_type it);
      pending_reqs.push_back(it);
      n_queued++;
   endtask

   task automatic push_write(logic [11:0] addr, logic signed [31:0] value);
      req_item_type it;
      it = blank_req(KIND_WRITE);
      it.addr = addr;
      it.value = value;
      if (!gen_written[addr]) written_addrs.push_back(addr);
      gen_written[addr] = 1'b1;
      push_req(it);
   endtask

   task automatic push_read(logic [11:0] addr);
      req_item_type it;
      it = blank_req(KIND_READ);
      it.addr = addr;
      push_req(it);
   endtask

   task automatic push_face(logic [11:0] a, logic [11:0] b, logic [11:0] c);
      req_item_type it;
      it = blank_req(KIND_TRI);
      it.va = a;
      it.vb = b;
      it.vc = c;
      push_req(it);
   endtask

   function automatic logic signed [31:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      if (r < 80) return $urandom;
      if (r < 87) return 32'sh7fff_ffff;
      if (r < 94) return 32'sh8000_0000;
      return 32'sh0;
   endfunction

   function automatic logic signed [31:0] pick_normal();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      if (r < 90) return 32'sh7fff_fff0;
      return 32'sh8000_0010;
   endfunction

   // lowest vertex whose record runs past the end of memory
   function automatic int first_outside(int unsigned s);
      return (Words - 5 + s - 1) / s;
   endfunction

   // one stride setting: load records, then random traffic
   task automatic run_phase(int unsigned s, int n_random, bit directed);
      int lim;
      int r;
      lim = (s == 0) ? Words : first_outside(s);
      if (lim > Words) lim = Words;
      for (int i = 0; i < 7; i++) verts[i] = 12'(i);
      verts[7] = 12'(lim - 1);
      foreach (verts[i]) begin
         for (int j = 0; j < 3; j++) push_write(12'(verts[i] * s + j), pick_position());
         for (int j = 3; j < 6; j++) push_write(12'(verts[i] * s + j), pick_normal());
      end
      if (directed) begin
         push_write(12'd4095, 32'sh7fff_ffff);
         push_write(12'd4094, 32'sh8000_0000);
         push_read(12'd4095);
         push_read(12'd4094);
         push_read(12'd0);
         push_req(blank_req(KIND_NOP));
         // flat face, then one that names a vertex twice
         push_face(verts[1], verts[1], verts[1]);
         push_face(verts[0], verts[0], verts[1]);
         push_face(verts[0], verts[1], verts[2]);
         push_face(verts[0], verts[2], verts[1]);
         // normal pushed into saturation
         push_write(12'(verts[3] * s + 3), 32'sh7fff_ffff);
         push_write(12'(verts[3] * s + 4), 32'sh8000_0000);
         push_write(12'(verts[3] * s + 5), 32'sh7fff_ffff);
         push_write(12'(verts[4] * s + 0), 32'sh8000_0000);
         push_write(12'(verts[5] * s + 1), 32'sh7fff_ffff);
         push_face(verts[3], verts[4], verts[5]);
         push_face(verts[5], verts[4], verts[3]);
         push_face(verts[7], verts[3], verts[6]);
         push_read(12'(verts[3] * s + 3));
         push_read(12'(verts[3] * s + 4));
         // records past the end of memory
         push_face(12'd4095, verts[0], verts[1]);
         push_face(verts[0], 12'(lim), verts[1]);
         push_face(verts[0], verts[1], 12'd4095);
      end
      for (int k = 0; k < n_random; k++) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            push_face(verts[$urandom_range(0, 7)], verts[$urandom_range(0, 7)],
                      verts[$urandom_range(0, 7)]);
         end else if (r < 70) begin
            push_write(12'(verts[$urandom_range(0, 7)] * s + $urandom_range(0, 2)),
                       pick_position());
         end else if (r < 75) begin
            push_write(12'($urandom), $urandom);
         end else if (r < 90) begin
            push_read(written_addrs[$urandom_range(0, written_addrs.size() - 1)]);
         end else if (r < 93) begin
            push_req(blank_req(KIND_NOP));
         end else if (lim < Words) begin
            case ($urandom_range(0, 2))
               0: push_face(12'($urandom_range(lim, 4095)), verts[0],
                            verts[$urandom_range(0, 7)]);
               1: push_face(verts[1], 12'($urandom_range(lim, 4095)), verts[2]);
               default: push_face(verts[2], verts[3], 12'($urandom_range(lim, 4095)));
            endcase
         end else begin
            push_face(verts[0], verts[1], verts[2]);
         end
      end
   endtask

   task automatic wait_drained();
      while (n_checked < n_queued) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // request driver
   req_item_type cur_req;
   int         req_gap = 0;
   bit         req_calm = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(predict_rsp(cur_req));
         if ($urandom_range(0, 199) == 0) req_calm = ~req_calm;
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               req_kind <= cur_req.kind;
               req_word_address <= cur_req.addr;
               req_word_value <= cur_req.value;
               req_vertex_a <= cur_req.va;
               req_vertex_b <= cur_req.vb;
               req_vertex_c <= cur_req.vc;
               req_valid <= 1'b1;
               req_gap = gap_len(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and back-pressure
   int         rsp_hold = 0;
   bit         rsp_calm = 1'b0;
   bit         long_hold_done = 1'b0;
   rsp_item_type exp_rsp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: response beat with nothing expected: value %h error %b",
                        $time, rsp_read_value, rsp_range_error);
               n_fail++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_read_value !== exp_rsp.word) begin
                  $display("%0t: read_value expected %h actual %h",
                           $time, exp_rsp.word, rsp_read_value);
                  n_fail++;
               end
               if (rsp_range_error !== exp_rsp.range_err) begin
                  $display("%0t: range_error expected %b actual %b",
                           $time, exp_rsp.range_err, rsp_range_error);
                  n_fail++;
               end
            end
            n_checked++;
         end
         if ($urandom_range(0, 199) == 0) rsp_calm = ~rsp_calm;
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && n_checked >= 300) begin
            // long stall so the request side backs up
            long_hold_done = 1'b1;
            rsp_hold = 600;
            rsp_ready <= 1'b0;
         end else begin
            rsp_hold = gap_len(rsp_calm);
            if (rsp_hold == 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_hold--;
               rsp_ready <= 1'b0;
            end
         end
      end
   end

   // phases over several strides
   int unsigned strides [7];

   initial begin
      strides = '{8, 6, 64, 3, 127, 0, 0};
      strides[5] = $urandom_range(6, 64);
      strides[6] = $urandom_range(6, 64);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (strides[p]) begin
         if (p > 0) begin
            @(posedge clock);
            csr_write_enable <= 1'b1;
            csr_write_data <= 7'(strides[p]);
            @(posedge clock);
            csr_write_enable <= 1'b0;
            shadow_stride = strides[p];
            @(negedge clock);
         end
         run_phase(strides[p], 170, p == 0 || p == 3);
         wait_drained();
      end
      repeat (20) @(posedge clock);
      if (n_fail == 0 && expected_rsps.size() == 0)
         $display("tb_mesh_vertex_normal_accumulator_top passed");
      else
         $display("tb_mesh_vertex_normal_accumulator_top failed");
      $finish;
   end

   // run limit
   initial begin
      #80_000_000;
      $display("tb_mesh_vertex_normal_accumulator_top failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mvna_pkg.sv
rtl/mesh_vertex_normal_accumulator_top.sv
bench/tb_mesh_vertex_normal_accumulator_top.sv
